// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files; modular_exponentiation.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("%m: assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- rtl/mexp_pkg.sv -----
// Shared types and constants of the modular exponentiation block.
package mexp_pkg;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_status;

endpackage

// ----- rtl/mexp_mulred.sv -----
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
module mexp_mulred #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [W-1:0]          i_a,
    input  logic [W-1:0]          i_b,
    input  logic [W-1:0]          i_mod,
    output mexp_pkg::t_mul_status o_stat,
    output logic [W-1:0]          o_prod
);
    import mexp_pkg::*;

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_a, n_a;
    logic [W-1:0]     r_b, n_b;
    logic [W:0]       r_m, n_m;
    logic [W-1:0]     r_acc, n_acc;

    logic [W+1:0]     w_sum;
    logic [W+1:0]     w_m1;
    logic [W+1:0]     w_m2;
    logic [W+1:0]     w_step;

    // 2*acc + addend stays below 3m, so at most 2m comes off
    always_comb begin
        w_sum = {1'b0, r_acc, 1'b0} + (r_b[W-1] ? {2'b00, r_a} : {(W+2){1'b0}});
        w_m1  = {1'b0, r_m};
        w_m2  = {r_m, 1'b0};
        if (w_sum >= w_m2) begin
            w_step = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            w_step = w_sum - w_m1;
        end else begin
            w_step = w_sum;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_a    = i_a;
            n_b    = i_b;
            // zero modulus means 2^W
            n_m    = {(i_mod == '0), i_mod};
            n_acc  = '0;
        end else if (r_busy) begin
            n_acc = w_step[W-1:0];
            n_b   = r_b << 1;
            if (r_cnt == CNT_W'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
        r_acc <= n_acc;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_acc;

endmodule

// ----- rtl/modular_exponentiation.sv -----
// Modular exponentiation top level: key registers, square-and-multiply sequencer.
// Computes base^exponent mod modulus by right-to-left square and multiply, using one
// bit-serial modular multiplier. The base is first reduced on the same multiplier.
// All W = OPERAND_WIDTH exponent bits are scanned.
// The input is not ready while a request is in work; the result sits in an output
// register, so a new request is taken while it waits. A zero exponent gives 1.
// Exponent (index 0, reset 0) and modulus (index 1, reset 1; zero means 2^W) must
// be written through the config port only while the block is idle; the block
// itself does not enforce this.
`include "assert_macros.svh"

module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mexp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [OPERAND_WIDTH-1:0]       i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [OPERAND_WIDTH-1:0]       i_base_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [OPERAND_WIDTH-1:0]       o_power_result
);
    import mexp_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_DISP = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SQR  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [W-1:0]     r_exponent;
    logic [W-1:0]     r_modulus;

    logic [2:0]       r_state, n_state;
    logic [W-1:0]     r_power, n_power;
    logic [W-1:0]     r_acc, n_acc;
    logic [W-1:0]     r_exp, n_exp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_result, n_result;
    logic             r_out_valid, n_out_valid;

    logic             w_start;
    logic [W-1:0]     w_op_a;
    logic [W-1:0]     w_op_b;
    logic [W-1:0]     w_prod;
    t_mul_status      w_mul_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= '0;
            r_modulus  <= W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_EXPONENT: r_exponent <= i_cfg_data;
                REG_MODULUS:  r_modulus  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_power     = r_power;
        n_acc       = r_acc;
        n_exp       = r_exp;
        n_cnt       = r_cnt;
        n_result    = r_result;
        n_out_valid = r_out_valid && !i_out_ready;
        w_start     = 1'b0;
        w_op_a      = r_power;
        w_op_b      = r_power;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    // base mod m computed as 1 * base on the multiplier
                    w_start = 1'b1;
                    w_op_a  = W'(1);
                    w_op_b  = i_base_value;
                    n_acc   = W'(1);
                    n_exp   = r_exponent;
                    n_cnt   = '0;
                    n_state = ST_RED;
                end
            end
            ST_RED: begin
                if (w_mul_stat.done) begin
                    n_power = w_prod;
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                w_start = 1'b1;
                if (r_exp[0]) begin
                    w_op_a  = r_acc;
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_SQR;
                end
            end
            ST_MUL: begin
                if (w_mul_stat.done) begin
                    n_acc   = w_prod;
                    w_start = 1'b1;
                    n_state = ST_SQR;
                end
            end
            ST_SQR: begin
                if (w_mul_stat.done) begin
                    n_power = w_prod;
                    n_exp   = r_exp >> 1;
                    if (r_cnt == CNT_W'(W - 1)) begin
                        n_state = ST_FIN;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = ST_DISP;
                    end
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_result    = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_power  <= n_power;
        r_acc    <= n_acc;
        r_exp    <= n_exp;
        r_result <= n_result;
    end

    mexp_mulred #(
        .W (W)
    ) u_mulred (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_op_a),
        .i_b     (w_op_b),
        .i_mod   (r_modulus),
        .o_stat  (w_mul_stat),
        .o_prod  (w_prod)
    );

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_result;

    `ASSERT_CLK(a_busy_state, i_clk, i_rst_n, w_mul_stat.busy |-> (r_state == ST_RED || r_state == ST_MUL || r_state == ST_SQR))
    `ASSERT_NEVER(a_ready_busy, i_clk, i_rst_n, o_in_ready && w_mul_stat.busy)
    `ASSERT_CLK(a_start_free, i_clk, i_rst_n, w_start |-> !w_mul_stat.busy)
    `ASSERT_CLK(a_result_hold, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_result)))

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 1ps

module tb;
    import mexp_pkg::*;

    localparam int W           = 32;
    localparam int WDOG_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 2200;
    localparam int RAND_PHASES = 18;
    localparam int PHASE_ITEMS = 15;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = REG_EXPONENT;
    logic [W-1:0]         cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    logic [W-1:0]         base_value = '0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    logic [W-1:0]         power_result;

    logic [W-1:0] key_exp = '0;
    logic [W-1:0] key_mod = W'(1);
    logic [W-1:0] power_q[$];
    logic [W-1:0] want;

    int snd_pct     = 0;
    int rcv_pct     = 0;
    int err_cnt     = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_keys      = 0;
    int idle_cycles = 0;

    modular_exponentiation #(
        .OPERAND_WIDTH(W)
    ) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_base_value  (base_value),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_power_result(power_result)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // right-to-left square and multiply; modulus zero stands for 2^W
    function automatic logic [W-1:0] modpow(input logic [W-1:0] b, input logic [W-1:0] e,
                                            input logic [W-1:0] m);
        logic [63:0] acc;
        logic [63:0] pw;
        logic [63:0] mm;
        if (e == '0)
            return W'(1);
        mm  = (m == '0) ? (64'd1 << W) : {32'd0, m};
        pw  = {32'd0, b} % mm;
        acc = 64'd1;
        for (int i = 0; i < W; i++) begin
            if (e[i])
                acc = (acc * pw) % mm;
            pw = (pw * pw) % mm;
        end
        return acc[W-1:0];
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready   <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (power_q.size() == 0) begin
                    $error("unexpected result: power_result %h", power_result);
                    err_cnt++;
                end else begin
                    want = power_q.pop_front();
                    n_checked++;
                    if (power_result !== want) begin
                        $error("power_result mismatch: expected %h, actual %h",
                               want, power_result);
                        err_cnt++;
                    end
                end
            end
            out_ready <= ($urandom_range(100, 1) > rcv_pct);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WDOG_LIMIT)
            @(posedge clk);
        $display("watchdog: no handshake in %0d cycles", WDOG_LIMIT);
        $display("** modular_exponentiation: FAILED **");
        $finish;
    end

    task automatic set_idle(input t_idle_mode md);
        case (md)
            IDLE_NONE: begin snd_pct = 0;  rcv_pct = 0;  end
            IDLE_SEND: begin snd_pct = 82; rcv_pct = 0;  end
            IDLE_RECV: begin snd_pct = 0;  rcv_pct = 82; end
            IDLE_BOTH: begin snd_pct = 11; rcv_pct = 11; end
            default:   begin snd_pct = 0;  rcv_pct = 0;  end
        endcase
    endtask

    // one request; valid stays up afterwards so back-to-back requests need no toggle
    task automatic send_base(input logic [W-1:0] b);
        while ($urandom_range(100, 1) <= snd_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        base_value <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        power_q.push_back(modpow(b, key_exp, key_mod));
        n_sent++;
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        while (power_q.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_we high; caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_EXPONENT: key_exp = val;
            REG_MODULUS:  key_mod = val;
            default: ;
        endcase
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] val);
        wait_results();
        write_reg(idx, val);
        cfg_we <= 1'b0;
        n_keys++;
    endtask

    task automatic set_key(input logic [W-1:0] e, input logic [W-1:0] m);
        wait_results();
        write_reg(REG_EXPONENT, e);
        write_reg(REG_MODULUS, m);
        cfg_we <= 1'b0;
        n_keys++;
    endtask

    task automatic test_reset_defaults();
        send_base('0);
        send_base('1);
        send_base(32'h1234_5678);
    endtask

    task automatic test_zero_exponent();
        set_reg(REG_MODULUS, 32'hFFFF_FFFF);
        send_base('0);
        send_base(32'd7);
    endtask

    task automatic test_unit_modulus();
        set_key(32'hFFFF_FFFF, 32'd1);
        send_base('0);
        send_base(32'd1);
        send_base('1);
    endtask

    task automatic test_full_width();
        set_reg(REG_MODULUS, 32'hFFFF_FFFF);
        send_base('0);
        send_base(32'd1);
        send_base(32'd2);
        send_base(32'hFFFF_FFFE);
        send_base(32'hFFFF_FFFF);
    endtask

    task automatic test_small_keys();
        set_key(32'd1, 32'hFFFF_FFFB);
        send_base(32'hFFFF_FFFF);
        send_base(32'd3);
        set_key(32'd2, 32'd2);
        send_base('0);
        send_base(32'd1);
        send_base(32'd3);
        set_key(32'd65537, 32'hC5A1_3F27);
        send_base(32'hDEAD_BEEF);
        send_base(32'h8000_0000);
    endtask

    task automatic pick_key(output logic [W-1:0] e, output logic [W-1:0] m);
        case ($urandom_range(7, 0))
            0:       e = '0;
            1:       e = '1;
            2:       e = $urandom_range(16, 1);
            3:       e = 32'd65537;
            default: e = $urandom;
        endcase
        case ($urandom_range(7, 0))
            0:       m = 32'd1;
            1:       m = '1;
            2:       m = $urandom_range(255, 2);
            3:       m = $urandom | 32'h8000_0000;
            4:       m = 32'd2;
            default: m = $urandom;
        endcase
        if (m == '0)
            m = 32'd1;
    endtask

    function automatic logic [W-1:0] pick_base(input logic [W-1:0] m);
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return '1;
            2:       return m - 1;
            3:       return m;
            4, 5:    return $urandom_range(m - 1, 0);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_keys();
        logic [W-1:0] e;
        logic [W-1:0] m;
        for (int p = 0; p < RAND_PHASES; p++) begin
            pick_key(e, m);
            set_key(e, m);
            set_idle(t_idle_mode'(p % 4));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // hold off until the block has handed back everything
                if (i == 7 && p % 3 == 0)
                    wait_results();
                send_base(pick_base(key_mod));
            end
        end
    endtask

    initial begin
        set_idle(IDLE_NONE);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_exponent();
        test_unit_modulus();
        test_full_width();
        test_small_keys();
        test_random_keys();

        wait_results();
        set_idle(IDLE_NONE);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (power_q.size() != 0) begin
            $error("%0d results never arrived", power_q.size());
            err_cnt++;
        end
        $display("Covered %0d bases (%0d checked) over %0d key settings,", n_sent, n_checked,
                 n_keys);
        $display("zero exponent, unit and full-width moduli, and four idle/stall patterns.");
        if (err_cnt == 0)
            $display("** modular_exponentiation: PASSED **");
        else
            $display("** modular_exponentiation: FAILED **");
        $finish;
    end

endmodule

// ----- modular_exponentiation.f -----
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_mulred.sv
rtl/modular_exponentiation.sv
sim/tb.sv
